// ----- src/sgap_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package sgap_pkg;

  localparam int unsigned DimW = 12;
  localparam int unsigned HgtW = 13;
  // wide enough for the tallest sum of shelf terms
  localparam int unsigned SumW = 16;

  typedef struct packed {
    logic [DimW-1:0] glyph_w;
    logic [DimW-1:0] glyph_h;
  } req_t;

  typedef struct packed {
    logic            ok;
    logic [DimW-1:0] slot_x;
    logic [DimW-1:0] slot_y;
    logic [HgtW-1:0] atlas_height;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_GROW
  } state_e;

endpackage

`default_nettype wire

// ----- src/shelf_glyph_atlas_packer_unit.sv -----
// Shelf packer for a glyph atlas of fixed width START_SIZE whose height doubles
// on demand up to MAX_SIZE. Pulse start_i with a word on req_i while busy_o is
// low; exactly one result word appears on rsp_o with valid_o high for a single
// cycle and must be taken then, as there is no way to hold it off. A request
// with a zero dimension answers in the next cycle and busy_o stays low.
// Otherwise the request walks a small sequencer: a placement check in the check
// state, a further check when a new shelf is opened, and for each growth pass a
// grow step per height doubling plus a last grow step to commit or give up. A
// placement that fits the current shelf is answered from the check state; one
// that grows the atlas passes through the grow state first, and the doubling
// loop in the grow state bounds its time in flight. busy_o is high while a
// request is in flight, and valid_o rises on the same edge at which busy_o falls.
`timescale 1ns / 1ps
`default_nettype none

module shelf_glyph_atlas_packer_unit #(
  parameter int unsigned START_SIZE = 512,
  parameter int unsigned MAX_SIZE   = 4096,
  parameter int unsigned PAD        = 1
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire sgap_pkg::req_t req_i,
  output logic               busy_o,
  output logic               valid_o,
  output sgap_pkg::rsp_t     rsp_o
);

  localparam int unsigned SW = sgap_pkg::SumW;
  localparam int unsigned HW = sgap_pkg::HgtW;
  localparam int unsigned DW = sgap_pkg::DimW;

  localparam logic [SW-1:0] AtlasW  = SW'(START_SIZE);
  localparam logic [SW-1:0] MaxH    = SW'(MAX_SIZE);
  localparam logic [SW-1:0] PadS    = SW'(PAD);
  localparam logic [HW-1:0] PadH    = HW'(PAD);
  localparam logic [HW-1:0] StartH  = HW'(START_SIZE);

  sgap_pkg::state_e state_q, state_d;

  logic          started_q, started_d;
  logic [HW-1:0] height_q, height_d;
  logic [HW-1:0] cx_q, cx_d;
  logic [HW-1:0] cy_q, cy_d;
  logic [HW-1:0] sh_q, sh_d;
  logic [DW-1:0] gw_q, gw_d;
  logic [DW-1:0] gh_q, gh_d;
  logic [SW-1:0] nh_q, nh_d;
  logic [SW-1:0] need_q, need_d;
  logic          valid_q, valid_d;
  sgap_pkg::rsp_t rsp_q, rsp_d;

  logic          accept;
  logic          zero_dim;
  logic [SW-1:0] fit_x_sum, fit_y_sum, shelf_sum, new_need, nh_clamp;
  logic          fit_here, fit_shelf, grow_more, grow_ok;

  assign accept   = start_i && (state_q == sgap_pkg::ST_IDLE);
  assign zero_dim = (req_i.glyph_w == '0) || (req_i.glyph_h == '0);

  // placement tests against the current shelf and a fresh one below it
  assign fit_x_sum = SW'(cx_q) + SW'(gw_q) + PadS;
  assign fit_y_sum = SW'(cy_q) + SW'(gh_q) + PadS;
  assign shelf_sum = SW'(cy_q) + SW'(sh_q) + PadS;
  assign new_need  = shelf_sum + SW'(gh_q) + PadS;
  assign fit_here  = (fit_x_sum <= AtlasW) && (fit_y_sum <= SW'(height_q));
  assign fit_shelf = (new_need <= SW'(height_q)) &&
                     ((SW'(gw_q) + (PadS << 1)) <= AtlasW);

  assign grow_more = (nh_q < need_q) && (nh_q < MaxH);
  assign nh_clamp  = (nh_q > MaxH) ? MaxH : nh_q;
  assign grow_ok   = nh_clamp > SW'(height_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sgap_pkg::ST_IDLE: begin
        if (accept && !zero_dim) state_d = sgap_pkg::ST_CHECK;
      end
      sgap_pkg::ST_CHECK: begin
        priority if (fit_here)  state_d = sgap_pkg::ST_IDLE;
        else if (fit_shelf)     state_d = sgap_pkg::ST_CHECK;
        else                    state_d = sgap_pkg::ST_GROW;
      end
      sgap_pkg::ST_GROW: begin
        priority if (grow_more) state_d = sgap_pkg::ST_GROW;
        else if (grow_ok)       state_d = sgap_pkg::ST_CHECK;
        else                    state_d = sgap_pkg::ST_IDLE;
      end
      default: state_d = sgap_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    started_d = started_q;
    height_d  = height_q;
    cx_d      = cx_q;
    cy_d      = cy_q;
    sh_d      = sh_q;
    gw_d      = gw_q;
    gh_d      = gh_q;
    nh_d      = nh_q;
    need_d    = need_q;
    valid_d   = 1'b0;
    rsp_d     = rsp_q;
    unique case (state_q)
      sgap_pkg::ST_IDLE: begin
        if (accept) begin
          gw_d = req_i.glyph_w;
          gh_d = req_i.glyph_h;
          if (zero_dim) begin
            // reject without touching atlas state
            valid_d            = 1'b1;
            rsp_d.ok           = 1'b0;
            rsp_d.slot_x       = '0;
            rsp_d.slot_y       = '0;
            rsp_d.atlas_height = height_q;
          end else if (!started_q) begin
            started_d = 1'b1;
            height_d  = StartH;
            cx_d      = PadH;
            cy_d      = PadH;
            sh_d      = '0;
          end
        end
      end
      sgap_pkg::ST_CHECK: begin
        priority if (fit_here) begin
          valid_d            = 1'b1;
          rsp_d.ok           = 1'b1;
          rsp_d.slot_x       = cx_q[DW-1:0];
          rsp_d.slot_y       = cy_q[DW-1:0];
          rsp_d.atlas_height = height_q;
          cx_d               = fit_x_sum[HW-1:0];
          if (HW'(gh_q) > sh_q) sh_d = HW'(gh_q);
        end else if (fit_shelf) begin
          // open a new shelf below the current one
          cy_d = shelf_sum[HW-1:0];
          cx_d = PadH;
          sh_d = '0;
        end else begin
          nh_d   = SW'(height_q);
          need_d = new_need;
        end
      end
      sgap_pkg::ST_GROW: begin
        priority if (grow_more) begin
          nh_d = nh_q << 1;
        end else if (grow_ok) begin
          height_d = nh_clamp[HW-1:0];
        end else begin
          valid_d            = 1'b1;
          rsp_d.ok           = 1'b0;
          rsp_d.slot_x       = '0;
          rsp_d.slot_y       = '0;
          rsp_d.atlas_height = height_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= sgap_pkg::ST_IDLE;
      started_q <= 1'b0;
      height_q  <= '0;
      cx_q      <= '0;
      cy_q      <= '0;
      sh_q      <= '0;
      valid_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      started_q <= started_d;
      height_q  <= height_d;
      cx_q      <= cx_d;
      cy_q      <= cy_d;
      sh_q      <= sh_d;
      valid_q   <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    gw_q   <= gw_d;
    gh_q   <= gh_d;
    nh_q   <= nh_d;
    need_q <= need_d;
    rsp_q  <= rsp_d;
  end

  assign busy_o  = (state_q != sgap_pkg::ST_IDLE);
  assign valid_o = valid_q;
  assign rsp_o   = rsp_q;

endmodule

`default_nettype wire

// ----- src/sgap_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sgap_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           start_i,
  input wire sgap_pkg::req_t req_i,
  input wire logic           busy_o,
  input wire logic           valid_o,
  input wire sgap_pkg::rsp_t rsp_o
);

  logic acc, acc_zero;
  assign acc      = start_i && !busy_o;
  assign acc_zero = acc && ((req_i.glyph_w == '0) || (req_i.glyph_h == '0));

  // a result only shows once the block has gone idle
  a_valid_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy_o) else $error("result while busy");

  a_zero_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_zero |=> valid_o && !rsp_o.ok) else $error("zero glyph not rejected");

  a_work_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && !acc_zero) |=> busy_o && !valid_o) else $error("request not taken up");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !rsp_o.ok) |-> (rsp_o.slot_x == '0) && (rsp_o.slot_y == '0))
    else $error("failed result carries a slot");

  a_ok_height: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && rsp_o.ok) |-> (rsp_o.atlas_height != '0))
    else $error("placed glyph in empty atlas");

endmodule

bind shelf_glyph_atlas_packer_unit sgap_checker u_sgap_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .req_i   (req_i),
  .busy_o  (busy_o),
  .valid_o (valid_o),
  .rsp_o   (rsp_o)
);

`default_nettype wire
